// ===== rtl/btpc_pkg.sv =====
// Shared types and constants for the barometric temperature/pressure compensation block.
`default_nettype none
package btpc_pkg;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pa;
    logic               divide_fault;
  } out_t;

  typedef enum logic [2:0] {
    CFG_AC1_AC2  = 3'd0,
    CFG_AC3_AC4  = 3'd1,
    CFG_AC5_AC6  = 3'd2,
    CFG_B1_B2    = 3'd3,
    CFG_MC_MD    = 3'd4,
    CFG_OSS      = 3'd5
  } cfg_idx_t;

  localparam logic [31:0] PRES_SCALE   = 32'd50000;
  localparam int          B5_OFFSET    = 4000;
  localparam int          X3_BIAS      = 32768;
  localparam logic [11:0] P_SQ_COEF    = 12'd3038;
  localparam logic [12:0] P_LIN_COEF   = 13'd7357;
  localparam int          P_OFFSET     = 3791;
  localparam logic [17:0] PRES_MAX     = 18'h3ffff;

endpackage
`default_nettype wire

// ===== rtl/btpc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage, with sideband.
`default_nettype none
module btpc_div #(
  parameter int NW = 32,
  parameter int DW = 33,
  parameter int SW = 18
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [NW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);

  logic          vld_r  [NW];
  logic [NW-1:0] nq_r   [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          v_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign nq_in   = in_num;
      assign rem_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_r[s-1];
      assign nq_in   = nq_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign den_in  = den_r[s-1];
      assign side_in = side_r[s-1];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      nq_r[s]   <= {nq_in[NW-2:0], ~diff[DW]};
      rem_r[s]  <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
      den_r[s]  <= den_in;
      side_r[s] <= side_in;
    end
  end

  assign out_valid = vld_r[NW-1];
  assign out_quo   = nq_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule
`default_nettype wire

// ===== rtl/baro_temp_pressure_compensation.sv =====
// Top level: fully pipelined barometric temperature and pressure compensation.
//
// One reading pair is taken every cycle (busy stays low) and its result strobes on out_valid
// once it has passed through every stage; results leave in input order and cannot be held off.
// The pipeline is made up of the two dividers, 27 and 32 stages at one quotient bit per stage,
// plus the multiply and add stages around them. Calibration writes are taken at any time
// (cfg_ready is always high) and must be made while no item is in flight.
`default_nettype none
module baro_temp_pressure_compensation (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire btpc_pkg::in_t    in_data,
  output logic                  out_valid,
  output btpc_pkg::out_t        out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data
);

  // calibration registers
  logic [31:0] ac12_r, ac34_r, ac56_r, b12_r, mcmd_r;
  logic [1:0]  oss_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac12_r <= '0;
      ac34_r <= '0;
      ac56_r <= '0;
      b12_r  <= '0;
      mcmd_r <= '0;
      oss_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (btpc_pkg::cfg_idx_t'(cfg_index))
        btpc_pkg::CFG_AC1_AC2: ac12_r <= cfg_data;
        btpc_pkg::CFG_AC3_AC4: ac34_r <= cfg_data;
        btpc_pkg::CFG_AC5_AC6: ac56_r <= cfg_data;
        btpc_pkg::CFG_B1_B2:   b12_r  <= cfg_data;
        btpc_pkg::CFG_MC_MD:   mcmd_r <= cfg_data;
        btpc_pkg::CFG_OSS:     oss_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  assign ac1 = ac12_r[31:16];
  assign ac2 = ac12_r[15:0];
  assign ac3 = ac34_r[31:16];
  assign ac4 = ac34_r[15:0];
  assign ac5 = ac56_r[31:16];
  assign ac6 = ac56_r[15:0];
  assign b1  = b12_r[31:16];
  assign b2  = b12_r[15:0];
  assign mc  = mcmd_r[31:16];
  assign md  = mcmd_r[15:0];

  // stage 0: capture, oversampling shift
  logic        v0_r;
  logic [15:0] ut0_r;
  logic [18:0] up0_r;
  logic [23:0] up_sh;

  assign up_sh = in_data.raw_pressure >> (4'd8 - {2'b00, oss_r});

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    ut0_r <= in_data.raw_temperature;
    up0_r <= up_sh[18:0];
  end

  // stage 1: (UT - AC6) * AC5
  logic               v1_r;
  logic signed [33:0] prod1_r;
  logic [18:0]        up1_r;
  logic signed [16:0] d1;

  assign d1 = $signed({1'b0, ut0_r}) - $signed({1'b0, ac6});

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    prod1_r <= d1 * $signed({1'b0, ac5});
    up1_r   <= up0_r;
  end

  // stage 2: divider operands for X2
  logic               v2_r;
  logic signed [18:0] x1_2_r;
  logic [26:0]        num2_r;
  logic [17:0]        den2_r;
  logic               qs2_r, f1_2_r;
  logic [18:0]        up2_r;
  logic signed [18:0] x1t, den1, negd;
  logic [15:0]        mc_neg, mc_mag;

  assign x1t    = prod1_r[33:15];
  assign den1   = x1t + md;
  assign negd   = -den1;
  assign mc_neg = 16'd0 - mcmd_r[31:16];
  assign mc_mag = mc[15] ? mc_neg : mcmd_r[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    x1_2_r <= x1t;
    num2_r <= {mc_mag, 11'b0};
    den2_r <= den1[18] ? negd[17:0] : den1[17:0];
    qs2_r  <= mc[15] ^ den1[18];
    f1_2_r <= (den1 == 19'sd0);
    up2_r  <= up1_r;
  end

  logic        dv1_valid;
  logic [26:0] q1;
  logic [39:0] side1;

  btpc_div #(.NW(27), .DW(18), .SW(40)) u_div_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_num    (num2_r),
    .in_den    (den2_r),
    .in_side   ({x1_2_r, qs2_r, f1_2_r, up2_r}),
    .out_valid (dv1_valid),
    .out_quo   (q1),
    .out_side  (side1)
  );

  // stage 3: B5, B6
  logic               v3_r;
  logic signed [28:0] b5_3_r;
  logic signed [27:0] b6_3_r;
  logic               f1_3_r;
  logic [18:0]        up3_r;
  logic signed [18:0] x1_d;
  logic signed [27:0] qv, x2_d;
  logic signed [28:0] b5_d, b6_d;

  assign x1_d = side1[39:21];
  assign qv   = $signed({1'b0, q1});
  assign x2_d = side1[20] ? -qv : qv;
  assign b5_d = x1_d + x2_d;
  assign b6_d = b5_d - 29'(btpc_pkg::B5_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= dv1_valid;
  end

  always_ff @(posedge clk) begin
    b5_3_r <= b5_d;
    b6_3_r <= b6_d[27:0];
    f1_3_r <= side1[19];
    up3_r  <= side1[18:0];
  end

  // stage 4: temperature, B6 products
  logic               v4_r;
  logic signed [15:0] t4_r;
  logic signed [55:0] sq4_r;
  logic signed [43:0] mac2_4_r, mac3_4_r;
  logic               f1_4_r;
  logic [18:0]        up4_r;
  logic signed [29:0] tsum;
  logic signed [25:0] tb;
  logic signed [15:0] t_sat;

  assign tsum = b5_3_r + 30'sd8;
  assign tb   = tsum[29:4];

  always_comb begin
    if (tb > 26'sd32767)       t_sat = 16'sh7fff;
    else if (tb < -26'sd32768) t_sat = 16'sh8000;
    else                       t_sat = tb[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    t4_r     <= t_sat;
    sq4_r    <= b6_3_r * b6_3_r;
    mac2_4_r <= ac2 * b6_3_r;
    mac3_4_r <= ac3 * b6_3_r;
    f1_4_r   <= f1_3_r;
    up4_r    <= up3_r;
  end

  // stage 5: B2 and B1 against B6^2 / 4096
  logic               v5_r;
  logic signed [15:0] t5_r;
  logic signed [59:0] mb2_5_r, mb1_5_r;
  logic signed [43:0] mac2_5_r, mac3_5_r;
  logic               f1_5_r;
  logic [18:0]        up5_r;
  logic [42:0]        sq12;

  assign sq12 = sq4_r[54:12];

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    t5_r     <= t4_r;
    mb2_5_r  <= b2 * $signed({1'b0, sq12});
    mb1_5_r  <= b1 * $signed({1'b0, sq12});
    mac2_5_r <= mac2_4_r;
    mac3_5_r <= mac3_4_r;
    f1_5_r   <= f1_4_r;
    up5_r    <= up4_r;
  end

  // stage 6: X3 sums for B3 and B4
  logic               v6_r;
  logic signed [15:0] t6_r;
  logic signed [49:0] x3a_6_r;
  logic signed [44:0] sb_6_r;
  logic               f1_6_r;
  logic [18:0]        up6_r;
  logic signed [48:0] x1a;
  logic signed [32:0] x2a;
  logic signed [30:0] x1b;
  logic signed [43:0] x2b;

  assign x1a = mb2_5_r[59:11];
  assign x2a = mac2_5_r[43:11];
  assign x1b = mac3_5_r[43:13];
  assign x2b = mb1_5_r[59:16];

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    t6_r    <= t5_r;
    x3a_6_r <= x1a + x2a;
    sb_6_r  <= x1b + x2b + 45'sd2;
    f1_6_r  <= f1_5_r;
    up6_r   <= up5_r;
  end

  // stage 7: B3 (truncating divide by 4), X3 + 32768
  logic               v7_r;
  logic signed [15:0] t7_r;
  logic [31:0]        b3_7_r, x3c_7_r;
  logic               f1_7_r;
  logic [18:0]        up7_r;
  logic signed [17:0] ac1x4;
  logic signed [50:0] s7a;
  logic signed [54:0] s7v;
  logic [54:0]        b3full;

  assign ac1x4  = {ac1, 2'b00};
  assign s7a    = ac1x4 + x3a_6_r;
  assign s7v    = (55'(s7a) <<< oss_r) + 55'sd2;
  assign b3full = s7v + {53'b0, s7v[54], s7v[54]};

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= v6_r;
  end

  always_ff @(posedge clk) begin
    t7_r    <= t6_r;
    b3_7_r  <= b3full[33:2];
    x3c_7_r <= sb_6_r[33:2] + 32'(btpc_pkg::X3_BIAS);
    f1_7_r  <= f1_6_r;
    up7_r   <= up6_r;
  end

  // stage 8: AC4 * X3, UP - B3
  logic               v8_r;
  logic signed [15:0] t8_r;
  logic [47:0]        b4p_8_r;
  logic [31:0]        b7a_8_r;
  logic               f1_8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else        v8_r <= v7_r;
  end

  always_ff @(posedge clk) begin
    t8_r    <= t7_r;
    b4p_8_r <= ac4 * x3c_7_r;
    b7a_8_r <= {13'b0, up7_r} - b3_7_r;
    f1_8_r  <= f1_7_r;
  end

  // stage 9: B4, B7
  logic               v9_r;
  logic signed [15:0] t9_r;
  logic [32:0]        b4_9_r;
  logic [31:0]        b7_9_r;
  logic               f_9_r;
  logic [32:0]        b4_d;
  logic [31:0]        pscale;
  logic [47:0]        b7p;

  assign b4_d   = b4p_8_r[47:15];
  assign pscale = btpc_pkg::PRES_SCALE >> oss_r;
  assign b7p    = b7a_8_r * pscale[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else        v9_r <= v8_r;
  end

  always_ff @(posedge clk) begin
    t9_r   <= t8_r;
    b4_9_r <= b4_d;
    b7_9_r <= b7p[31:0];
    f_9_r  <= f1_8_r || (b4_d == 33'd0);
  end

  logic        big9;
  logic [31:0] num9;

  assign big9 = b7_9_r[31];
  assign num9 = big9 ? b7_9_r : {b7_9_r[30:0], 1'b0};

  logic        dv2_valid;
  logic [31:0] q2;
  logic [17:0] side2;

  btpc_div #(.NW(32), .DW(33), .SW(18)) u_div_pres (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v9_r),
    .in_num    (num9),
    .in_den    (b4_9_r),
    .in_side   ({t9_r, f_9_r, big9}),
    .out_valid (dv2_valid),
    .out_quo   (q2),
    .out_side  (side2)
  );

  // stage 10: raw pressure
  logic               v10_r;
  logic signed [15:0] t10_r;
  logic [32:0]        p10_r;
  logic               f10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v10_r <= 1'b0;
    else        v10_r <= dv2_valid;
  end

  always_ff @(posedge clk) begin
    t10_r <= side2[17:2];
    f10_r <= side2[1];
    p10_r <= side2[0] ? {q2, 1'b0} : {1'b0, q2};
  end

  // stage 11: (p/256)^2, p * 7357
  logic               v11_r;
  logic signed [15:0] t11_r;
  logic [32:0]        p11_r;
  logic [49:0]        sqp11_r;
  logic [45:0]        m7_11_r;
  logic               f11_r;
  logic [24:0]        ps;

  assign ps = p10_r[32:8];

  always_ff @(posedge clk) begin
    if (!rst_n) v11_r <= 1'b0;
    else        v11_r <= v10_r;
  end

  always_ff @(posedge clk) begin
    t11_r   <= t10_r;
    p11_r   <= p10_r;
    sqp11_r <= ps * ps;
    m7_11_r <= p10_r * btpc_pkg::P_LIN_COEF;
    f11_r   <= f10_r;
  end

  // stage 12: * 3038, ceiling of p * 7357 / 65536
  logic               v12_r;
  logic signed [15:0] t12_r;
  logic [32:0]        p12_r;
  logic [61:0]        m30_12_r;
  logic [30:0]        m7c_12_r;
  logic               f12_r;
  logic [46:0]        m7s;

  assign m7s = {1'b0, m7_11_r} + 47'd65535;

  always_ff @(posedge clk) begin
    if (!rst_n) v12_r <= 1'b0;
    else        v12_r <= v11_r;
  end

  always_ff @(posedge clk) begin
    t12_r    <= t11_r;
    p12_r    <= p11_r;
    m30_12_r <= sqp11_r * btpc_pkg::P_SQ_COEF;
    m7c_12_r <= m7s[46:16];
    f12_r    <= f11_r;
  end

  // stage 13: X1 + X2 + 3791
  logic               v13_r;
  logic signed [15:0] t13_r;
  logic [32:0]        p13_r;
  logic signed [47:0] s13_r;
  logic               f13_r;
  logic [45:0]        x1p;

  assign x1p = m30_12_r[61:16];

  always_ff @(posedge clk) begin
    if (!rst_n) v13_r <= 1'b0;
    else        v13_r <= v12_r;
  end

  always_ff @(posedge clk) begin
    t13_r <= t12_r;
    p13_r <= p12_r;
    s13_r <= $signed({2'b00, x1p}) + 48'(btpc_pkg::P_OFFSET)
             - $signed({17'b0, m7c_12_r});
    f13_r <= f12_r;
  end

  // stage 14: final pressure, saturate, fault masking
  logic               out_valid_r;
  btpc_pkg::out_t     out_data_r;
  logic signed [43:0] corr;
  logic signed [47:0] pf;
  logic [17:0]        p_sat;
  btpc_pkg::out_t     out_nxt;

  assign corr = s13_r[47:4];
  assign pf   = $signed({15'b0, p13_r}) + corr;

  always_comb begin
    if (pf < 48'sd0)            p_sat = 18'd0;
    else if (pf > 48'sd262143)  p_sat = btpc_pkg::PRES_MAX;
    else                        p_sat = pf[17:0];
    out_nxt.temperature_tenths = f13_r ? 16'sd0 : t13_r;
    out_nxt.pressure_pa        = f13_r ? 18'd0 : p_sat;
    out_nxt.divide_fault       = f13_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v13_r;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
